/* rtl/ddwrl_pkg.sv */
// Package for the differential-drive wheel rate limiter.
// Widths, register indexes and the divider operand and tag widths. No dependencies.
`default_nettype none
package ddwrl_pkg;
	localparam int VelW   = 24;
	localparam int HtW    = 16;
	localparam int CircW  = 17;
	localparam int MaxW   = 20;
	localparam int PprW   = 11;
	localparam int OutW   = 16;
	localparam int CfgW   = 20;
	localparam int IdxW   = 2;
	localparam int NumW   = 42;   // v*2^16 +/- w*ht, signed
	localparam int RateW  = 42;   // wheel rate, signed
	localparam int SclW   = 62;   // s*rate, signed
	localparam int DivW   = SclW; // divider operand and quotient width
	localparam int DivTagW = 2 * RateW + 2; // side data carried through a divider
	localparam int PulseLimit = 32767;

	typedef enum logic [IdxW-1:0] {
		REG_HALF_TRACK = 2'd0,
		REG_CIRC       = 2'd1,
		REG_MAX_RPS    = 2'd2,
		REG_PPR        = 2'd3
	} reg_idx_t;
endpackage
`default_nettype wire

/* rtl/ddwrl_if.sv */
// Valid/ready stream interfaces for the wheel rate limiter.
// Depends on ddwrl_pkg for field widths.
`default_nettype none
interface ddwrl_cmd_if import ddwrl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [VelW-1:0] linear_velocity;
	logic signed [VelW-1:0] angular_velocity;
	modport source (output valid, linear_velocity, angular_velocity, input ready);
	modport sink   (input valid, linear_velocity, angular_velocity, output ready);
endinterface

interface ddwrl_rate_if import ddwrl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [OutW-1:0] left_pulse_rate;
	logic signed [OutW-1:0] right_pulse_rate;
	modport source (output valid, left_pulse_rate, right_pulse_rate, input ready);
	modport sink   (input valid, left_pulse_rate, right_pulse_rate, output ready);
endinterface
`default_nettype wire

/* rtl/ddwrl_div.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on ddwrl_pkg. Stalls with the shared enable; carries a tag alongside.
`default_nettype none
module ddwrl_div import ddwrl_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic signed [DivW-1:0] num,
	input  wire logic signed [DivW-1:0] den,
	input  wire logic [DivTagW-1:0]     tag_in,
	output logic                        out_valid,
	output logic signed [DivW-1:0]      quo,
	output logic [DivTagW-1:0]          tag_out
);
	// magnitudes; DivW bits hold |num| for every signed DivW-bit value
	logic [DivW-1:0] mag_n;
	logic [DivW-1:0] mag_d;
	assign mag_n = num[DivW-1] ? DivW'(-num) : DivW'(num);
	assign mag_d = den[DivW-1] ? DivW'(-den) : DivW'(den);

	logic [DivW-1:0]    q_s   [DivW+1];
	logic [DivW:0]      rem_s [DivW+1];
	logic [DivW-1:0]    d_s   [DivW+1];
	logic               neg_s [DivW+1];
	logic               v_s   [DivW+1];
	logic [DivTagW-1:0] tag_s [DivW+1];

	assign q_s[0]   = mag_n;
	assign rem_s[0] = '0;
	assign d_s[0]   = mag_d;
	assign neg_s[0] = num[DivW-1] ^ den[DivW-1];
	assign v_s[0]   = in_valid;
	assign tag_s[0] = tag_in;

	// restoring step k: shift in the top dividend bit, trial subtract
	for (genvar k = 0; k < DivW; k++) begin : g_step
		logic [DivW:0] sh;
		logic [DivW:0] diff;
		logic          ge;
		assign sh   = {rem_s[k][DivW-1:0], q_s[k][DivW-1]};
		assign diff = sh - {1'b0, d_s[k]};
		assign ge   = (sh >= {1'b0, d_s[k]});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff : sh;
				q_s[k+1]   <= {q_s[k][DivW-2:0], ge};
				d_s[k+1]   <= d_s[k];
				neg_s[k+1] <= neg_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[DivW];
	assign quo       = neg_s[DivW] ? DivW'(-q_s[DivW]) : DivW'(q_s[DivW]);
	assign tag_out   = tag_s[DivW];
endmodule
`default_nettype wire

/* rtl/diff_drive_wheel_rate_limiter.sv */
// Differential-drive wheel rate limiter: velocity command in, wheel pulse rates out.
// Depends on ddwrl_pkg, ddwrl_if and ddwrl_div.
//
// Usage: cmd carries (linear_velocity, angular_velocity); rate returns one
// (left_pulse_rate, right_pulse_rate) request per command, in order.
// Configuration is written through cfg_we/cfg_idx/cfg_data; the user must write it
// only while idle; the block does not enforce this. Throughput: one command per
// cycle while the output is not stalled. The path from an accepted command to
// rate.valid is formed by two bit-per-stage divider pipelines in series, 62
// stages each: the wheel rate divide by circumference and the ratio scaling
// divide, plus seven more register stages for the turn product, numerators,
// limit, scale product, final rates, pulse products and the output register.
// The whole pipeline advances together; when the receiver holds ready low
// and the output stage is full, every stage holds, so nothing is lost.
// cmd.ready is high whenever the output is free or being taken.
// Reset clears all valid bits and loads the default register values.
`default_nettype none
module diff_drive_wheel_rate_limiter import ddwrl_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	ddwrl_cmd_if.sink            cmd,
	ddwrl_rate_if.source         rate,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_idx,
	input  wire logic [CfgW-1:0] cfg_data
);
	// configuration registers
	logic [HtW-1:0]   ht_q;
	logic [CircW-1:0] circ_q;
	logic [MaxW-1:0]  smax_q;
	logic [PprW-1:0]  ppr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ht_q   <= HtW'(9011);
			circ_q <= CircW'(30883);
			smax_q <= MaxW'(546133);
			ppr_q  <= PprW'(1216);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_HALF_TRACK: ht_q   <= cfg_data[HtW-1:0];
				REG_CIRC:       circ_q <= cfg_data[CircW-1:0];
				REG_MAX_RPS:    smax_q <= cfg_data[MaxW-1:0];
				REG_PPR:        ppr_q  <= cfg_data[PprW-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_q;
	assign en = !out_v_q || rate.ready;
	assign cmd.ready = en;

	// stage 1: turn term product
	logic        v1_s1;
	logic signed [VelW-1:0]  vel_s1;
	logic signed [VelW+HtW:0] turn_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (en) v1_s1 <= cmd.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			vel_s1  <= cmd.linear_velocity;
			turn_s1 <= cmd.angular_velocity * $signed({1'b0, ht_q});
		end
	end

	// stage 2: numerators
	logic v_s2;
	logic signed [NumW-1:0] nl_s2, nr_s2;
	logic signed [NumW-1:0] vs;
	assign vs = {{(NumW-VelW-16){vel_s1[VelW-1]}}, vel_s1, 16'd0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v1_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nl_s2 <= vs + NumW'(turn_s1);
			nr_s2 <= vs - NumW'(turn_s1);
		end
	end

	// wheel rate dividers
	logic signed [DivW-1:0] cdiv;
	assign cdiv = DivW'({1'b0, (circ_q == '0) ? CircW'(1) : circ_q});
	logic dl_v, dr_v;
	logic signed [DivW-1:0] l_q, r_q;
	logic signed [RateW-1:0] l_d, r_d;
	logic [DivTagW-1:0] tl_u, tr_u;
	ddwrl_div u_div_l (
		.clk, .arst_n, .en, .in_valid(v_s2), .num(DivW'(nl_s2)), .den(cdiv),
		.tag_in('0), .out_valid(dl_v), .quo(l_q), .tag_out(tl_u));
	ddwrl_div u_div_r (
		.clk, .arst_n, .en, .in_valid(v_s2), .num(DivW'(nr_s2)), .den(cdiv),
		.tag_in('0), .out_valid(dr_v), .quo(r_q), .tag_out(tr_u));
	// wheel rates fit in RateW bits
	assign l_d = RateW'(l_q);
	assign r_d = RateW'(r_q);

	// stage 3: classify, pick scaled numerator/divisor
	logic signed [RateW-1:0] s;
	assign s = RateW'({1'b0, smax_q});
	logic v_s3;
	logic signed [RateW-1:0] lo_s3, ro_s3, big_s3, oth_s3;
	logic scale_s3, left_small_s3;
	logic signed [RateW-1:0] c_lo, c_ro, c_big, c_oth;
	logic c_scale, c_left;
	always_comb begin
		c_lo = l_d; c_ro = r_d; c_big = l_d; c_oth = r_d;
		c_scale = 1'b0; c_left = 1'b0;
		if (l_d < 0 && r_d > 0) begin
			c_lo = (l_d < -s) ? -s : l_d;
			c_ro = (r_d > s) ? s : r_d;
		end else if (l_d > 0 && r_d < 0) begin
			c_ro = (r_d < -s) ? -s : r_d;
			c_lo = (l_d > s) ? s : l_d;
		end else if (l_d > s || r_d > s) begin
			if (l_d > r_d) begin
				c_scale = 1'b1; c_big = l_d; c_oth = r_d; c_lo = s;
			end else if (r_d > l_d) begin
				c_scale = 1'b1; c_left = 1'b1; c_big = r_d; c_oth = l_d; c_ro = s;
			end else begin
				c_lo = s; c_ro = s;
			end
		end else if (l_d < -s || r_d < -s) begin
			if (l_d < r_d) begin
				c_scale = 1'b1; c_big = l_d; c_oth = r_d; c_lo = -s;
			end else if (r_d < l_d) begin
				c_scale = 1'b1; c_left = 1'b1; c_big = r_d; c_oth = l_d; c_ro = -s;
			end else begin
				c_lo = -s; c_ro = -s;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= dl_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= c_lo; ro_s3 <= c_ro; big_s3 <= c_big; oth_s3 <= c_oth;
			scale_s3 <= c_scale; left_small_s3 <= c_left;
		end
	end

	// stage 4: s * other; the sign of the pinned limit follows big, so
	// (+/-s * oth)/big equals (s*oth)/|big| with the sign of big folded in
	logic v_s4;
	logic signed [SclW-1:0] prod_s4;
	logic signed [RateW-1:0] lo_s4, ro_s4, big_s4;
	logic [1:0] flg_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= oth_s3 * $signed({1'b0, smax_q});
			big_s4  <= big_s3[RateW-1] ? -big_s3 : big_s3;
			lo_s4 <= lo_s3; ro_s4 <= ro_s3;
			flg_s4 <= {scale_s3, left_small_s3};
		end
	end

	// scaling divider; side data travel in the tag
	logic sv;
	logic signed [SclW-1:0] sq;
	logic [DivTagW-1:0] stag;
	logic signed [SclW-1:0] bigw;
	assign bigw = SclW'(big_s4);
	ddwrl_div u_div_s (
		.clk, .arst_n, .en, .in_valid(v_s4), .num(prod_s4), .den(bigw),
		.tag_in({lo_s4, ro_s4, flg_s4}), .out_valid(sv), .quo(sq), .tag_out(stag));

	// stage 5: final rates
	logic v_s5;
	logic signed [RateW-1:0] fl_s5, fr_s5;
	logic signed [RateW-1:0] t_lo, t_ro;
	assign t_lo = stag[DivTagW-1 -: RateW];
	assign t_ro = stag[RateW+1 -: RateW];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= sv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s5 <= (stag[1] && stag[0])  ? RateW'(sq) : t_lo;
			fr_s5 <= (stag[1] && !stag[0]) ? RateW'(sq) : t_ro;
		end
	end

	// stage 6: pulse products
	localparam int PW = RateW + PprW + 1;
	logic v_s6;
	logic signed [PW-1:0] pl_s6, pr_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s6 <= fl_s5 * $signed({1'b0, ppr_q});
			pr_s6 <= fr_s5 * $signed({1'b0, ppr_q});
		end
	end

	// truncate toward zero by 2^16, saturate
	function automatic logic signed [OutW-1:0] to_pulse(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] adj;
		logic signed [PW-17:0] q;
		adj = p[PW-1] ? p + PW'(65535) : p;
		q = adj[PW-1:16];
		if (q > PulseLimit) return OutW'(PulseLimit);
		else if (q < -PulseLimit) return OutW'(-PulseLimit);
		else return OutW'(q);
	endfunction

	logic signed [OutW-1:0] ol_q, or_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ol_q <= to_pulse(pl_s6);
			or_q <= to_pulse(pr_s6);
		end
	end

	assign rate.valid = out_v_q;
	assign rate.left_pulse_rate = ol_q;
	assign rate.right_pulse_rate = or_q;

	logic unused;
	assign unused = ^{dr_v, tl_u, tr_u, l_q[DivW-1:RateW], r_q[DivW-1:RateW],
		sq[SclW-1:RateW]};
endmodule
`default_nettype wire

/* rtl/ddwrl_checker.sv */
// Port-level checks for the wheel rate limiter, bound to the top level.
// Depends on ddwrl_pkg and the top-level ports.
`default_nettype none
module ddwrl_port_props import ddwrl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [OutW-1:0] left_rate,
	input wire logic signed [OutW-1:0] right_rate
);
	// a stalled request keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_rate) && $stable(right_rate))
		else $error("stalled result changed");
	// input is taken whenever the output side is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with empty output");
	// the whole pipeline stalls with the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during stall");
	// outputs stay in the saturated range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_rate != -16'sd32768 && right_rate != -16'sd32768)
		else $error("result out of range");
endmodule

bind diff_drive_wheel_rate_limiter ddwrl_port_props u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(cmd.valid), .in_ready(cmd.ready),
	.out_valid(rate.valid), .out_ready(rate.ready),
	.left_rate(rate.left_pulse_rate), .right_rate(rate.right_pulse_rate));
`default_nettype wire
